// File: design/lattice_cosine_transform_unit_macros.svh
// Assertion helpers
`ifndef LATTICE_COSINE_TRANSFORM_UNIT_MACROS_SVH
`define LATTICE_COSINE_TRANSFORM_UNIT_MACROS_SVH

// same-cycle implication
`define LCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lct check failed");

// next-cycle implication
`define LCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lct check failed");

`endif

// File: design/lct_pkg.sv
`timescale 1ns / 1ps
package lct_pkg;

  localparam int MAX_POINTS     = 1024;
  localparam int ADDR_W         = $clog2(MAX_POINTS);
  localparam int CNT_W          = ADDR_W + 1;
  localparam int IW             = 8;
  localparam int SUM_W          = IW + ADDR_W;
  localparam int WEIGHT_W       = 32;
  localparam int POINT_W        = 3 * IW + WEIGHT_W;
  localparam int PHASE_W        = 16;
  localparam int DIV_W          = PHASE_W + IW;
  localparam int COS_TABLE_BITS = 10;
  localparam int COS_LEN        = (1 << COS_TABLE_BITS) + 1;
  localparam int COS_W          = 16;
  localparam int PROD_W         = WEIGHT_W + COS_W;
  localparam int ACC_W          = PROD_W + ADDR_W;
  localparam int VALUE_W        = 48;
  localparam int QDEPTH         = 2;

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOT_FULL = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_OUTSIDE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [IW-1:0]    ix;
    logic [IW-1:0]    iy;
    logic [IW-1:0]    iz;
    logic [IW:0]      nx;
    logic [IW:0]      ny;
    logic [IW:0]      nz;
    logic [CNT_W-1:0] count;
    status_e          status;
  } job_t;

  typedef logic signed [COS_W-1:0] cos_rom_t [COS_LEN];

  // divide by (2k-1)*(2k), truncating toward zero
  function automatic longint taylor_div(longint v, int k);
    case (k)
      1:       return v / 64'sd2;
      2:       return v / 64'sd12;
      3:       return v / 64'sd30;
      4:       return v / 64'sd56;
      5:       return v / 64'sd90;
      6:       return v / 64'sd132;
      7:       return v / 64'sd182;
      8:       return v / 64'sd240;
      9:       return v / 64'sd306;
      default: return v / 64'sd380;
    endcase
  endfunction

  // Q1.15 quarter-wave cosine, Taylor series in Q30
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t t;
    longint   x;
    longint   x2;
    longint   term;
    longint   sum;
    longint   r;
    int       e;
    int       k;
    for (e = 0; e < COS_LEN - 1; e++) begin
      x    = (HALF_PI_Q30 * longint'(e)) >>> COS_TABLE_BITS;
      x2   = (x * x) / Q30_ONE;
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (k = 1; k <= 10; k++) begin
        term = -taylor_div((term * x2) / Q30_ONE, k);
        sum  = sum + term;
      end
      if (sum < 0) sum = 0;
      r = (sum * 32767 + (64'sd1 <<< 29)) / Q30_ONE;
      if (r > 32767) r = 32767;
      t[e] = COS_W'(r);
    end
    t[COS_LEN-1] = '0;
    return t;
  endfunction

endpackage

// File: design/lct_ram.sv
`timescale 1ns / 1ps
module lct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/lct_front.sv
`timescale 1ns / 1ps
module lct_front import lct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [IW-1:0]       index_x_i,
  input  logic [IW-1:0]       index_y_i,
  input  logic [IW-1:0]       index_z_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic                back_idle_i,
  input  logic                q_full_i,
  input  logic                q_empty_i,
  output logic                q_push_o,
  output job_t                q_job_o,
  output logic                ram_we_o,
  output logic [ADDR_W-1:0]   ram_waddr_o,
  output logic [POINT_W-1:0]  ram_wdata_o
);

  logic signed [IW-1:0]    min_q [3];
  logic signed [IW-1:0]    max_q [3];
  logic signed [SUM_W-1:0] sum_q [3];
  logic [CNT_W-1:0]        count_q;
  logic signed [IW-1:0]    idx [3];
  logic [IW:0]             size [3];
  logic                    accept;
  logic                    is_load;
  logic                    is_query;
  logic                    is_clear;
  logic                    outside;
  logic                    sums_nz;

  assign idx[0] = $signed(index_x_i);
  assign idx[1] = $signed(index_y_i);
  assign idx[2] = $signed(index_z_i);

  assign is_load  = kind_i == KIND_LOAD;
  assign is_query = kind_i == KIND_QUERY;
  assign is_clear = kind_i == KIND_CLEAR;

  assign in_stall_o = in_valid_i &&
                      ((is_clear && !(back_idle_i && q_empty_i)) || (is_query && q_full_i));
  assign accept     = in_valid_i && !in_stall_o;

  assign ram_we_o    = accept && is_load && (count_q != CNT_W'(MAX_POINTS));
  assign ram_waddr_o = count_q[ADDR_W-1:0];
  assign ram_wdata_o = {index_x_i, index_y_i, index_z_i, weight_i};

  always_comb begin
    outside = 1'b0;
    sums_nz = 1'b0;
    for (int d = 0; d < 3; d++) begin
      size[d] = ({max_q[d][IW-1], max_q[d]} - {min_q[d][IW-1], min_q[d]}) + (IW+1)'(1);
      if (idx[d] < min_q[d] || idx[d] > max_q[d]) outside = 1'b1;
      if (sum_q[d] != '0) sums_nz = 1'b1;
    end
  end

  always_comb begin
    q_job_o.ix    = index_x_i;
    q_job_o.iy    = index_y_i;
    q_job_o.iz    = index_z_i;
    q_job_o.nx    = size[0];
    q_job_o.ny    = size[1];
    q_job_o.nz    = size[2];
    q_job_o.count = count_q;
    if (count_q == '0)  q_job_o.status = STAT_EMPTY;
    else if (sums_nz)   q_job_o.status = STAT_NOT_FULL;
    else if (outside)   q_job_o.status = STAT_OUTSIDE;
    else                q_job_o.status = STAT_OK;
  end

  assign q_push_o = accept && is_query;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int d = 0; d < 3; d++) begin
        min_q[d] <= '0;
        max_q[d] <= '0;
        sum_q[d] <= '0;
      end
    end else if (accept && is_clear) begin
      count_q <= '0;
      for (int d = 0; d < 3; d++) begin
        min_q[d] <= '0;
        max_q[d] <= '0;
        sum_q[d] <= '0;
      end
    end else if (ram_we_o) begin
      count_q <= count_q + CNT_W'(1);
      for (int d = 0; d < 3; d++) begin
        if (idx[d] < min_q[d]) min_q[d] <= idx[d];
        if (idx[d] > max_q[d]) max_q[d] <= idx[d];
        sum_q[d] <= sum_q[d] + {{(SUM_W-IW){idx[d][IW-1]}}, idx[d]};
      end
    end
  end

endmodule

// File: design/lct_queue.sv
`timescale 1ns / 1ps
module lct_queue import lct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = $clog2(QDEPTH);
  localparam int FW = $clog2(QDEPTH + 1);

  job_t          slot_q [QDEPTH];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [FW-1:0] fill_q;

  assign full_o  = fill_q == FW'(QDEPTH);
  assign empty_o = fill_q == '0;
  assign job_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i)      fill_q <= fill_q + FW'(1);
      else if (pop_i && !push_i) fill_q <= fill_q - FW'(1);
    end
  end

endmodule

// File: design/lct_back.sv
`timescale 1ns / 1ps
module lct_back import lct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  job_t                q_job_i,
  output logic                q_pop_o,
  output logic [ADDR_W-1:0]   ram_raddr_o,
  input  logic [POINT_W-1:0]  ram_rdata_i,
  output logic                idle_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VALUE_W-1:0]  value_o,
  output logic [1:0]          status_o
);

  localparam cos_rom_t COS_ROM = build_cos_rom();

  typedef enum logic [9:0] {
    B_IDLE = 10'b0000000001,
    B_READ = 10'b0000000010,
    B_PREP = 10'b0000000100,
    B_DIV1 = 10'b0000001000,
    B_DIV2 = 10'b0000010000,
    B_COS  = 10'b0000100000,
    B_MUL  = 10'b0001000000,
    B_ACC  = 10'b0010000000,
    B_FIN  = 10'b0100000000,
    B_OUT  = 10'b1000000000
  } bstate_e;

  bstate_e                   state_q, state_d;
  job_t                      job_q;
  logic [CNT_W-1:0]          p_q;
  logic [1:0]                d_q;
  logic [$clog2(DIV_W)-1:0]  cnt_q;
  logic [DIV_W-1:0]          num_q;
  logic [IW:0]               rem_q;
  logic                      neg_q;
  logic [PHASE_W-1:0]        phase_q;
  logic signed [COS_W-1:0]   cos_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [VALUE_W-1:0]        value_q;
  logic [1:0]                status_q;

  logic signed [IW-1:0]      idx_sel;
  logic signed [IW-1:0]      n_sel;
  logic [IW:0]               size_sel;
  logic signed [2*IW-1:0]    mprod;
  logic [2*IW-1:0]           mag;
  logic [IW+1:0]             rem_t;
  logic                      ge;
  logic [IW:0]               rem_n;
  logic [DIV_W-1:0]          num_n;
  logic [IW:0]               rmod;
  logic [1:0]                quad;
  logic [COS_TABLE_BITS-1:0] m;
  logic [COS_TABLE_BITS:0]   rom_idx;
  logic signed [COS_W-1:0]   tval;
  logic signed [ACC_W-1:0]   shifted;
  logic                      last_pt;

  assign ram_raddr_o = p_q[ADDR_W-1:0];
  assign idle_o      = state_q == B_IDLE;
  assign q_pop_o     = (state_q == B_IDLE) && !q_empty_i;
  assign out_valid_o = state_q == B_OUT;
  assign value_o     = value_q;
  assign status_o    = status_q;

  always_comb begin
    unique case (d_q)
      2'd0: begin
        idx_sel  = $signed(job_q.ix);
        n_sel    = $signed(ram_rdata_i[POINT_W-1 -: IW]);
        size_sel = job_q.nx;
      end
      2'd1: begin
        idx_sel  = $signed(job_q.iy);
        n_sel    = $signed(ram_rdata_i[POINT_W-IW-1 -: IW]);
        size_sel = job_q.ny;
      end
      default: begin
        idx_sel  = $signed(job_q.iz);
        n_sel    = $signed(ram_rdata_i[POINT_W-2*IW-1 -: IW]);
        size_sel = job_q.nz;
      end
    endcase
  end

  assign mprod = idx_sel * n_sel;
  assign mag   = mprod[2*IW-1] ? (2*IW)'(-mprod) : (2*IW)'(mprod);

  // restoring divider step
  assign rem_t = {rem_q, num_q[DIV_W-1]};
  assign ge    = rem_t >= {1'b0, size_sel};
  assign rem_n = ge ? (IW+1)'(rem_t - {1'b0, size_sel}) : rem_t[IW:0];
  assign num_n = {num_q[DIV_W-2:0], ge};
  assign rmod  = (neg_q && rem_n != '0) ? size_sel - rem_n : rem_n;

  assign quad    = phase_q[PHASE_W-1 -: 2];
  assign m       = phase_q[PHASE_W-3 -: COS_TABLE_BITS];
  assign rom_idx = quad[0] ? (COS_TABLE_BITS+1)'(COS_LEN - 1) - {1'b0, m} : {1'b0, m};
  assign tval    = COS_ROM[rom_idx];

  assign shifted = acc_q >>> 8;
  assign last_pt = (p_q + CNT_W'(1)) == job_q.count;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (!q_empty_i) state_d = (q_job_i.status == STAT_OK) ? B_READ : B_FIN;
      B_READ: state_d = B_PREP;
      B_PREP: state_d = B_DIV1;
      B_DIV1: if (cnt_q == '0) state_d = B_DIV2;
      B_DIV2: if (cnt_q == '0) state_d = (d_q == 2'd2) ? B_COS : B_PREP;
      B_COS:  state_d = B_MUL;
      B_MUL:  state_d = B_ACC;
      B_ACC:  state_d = last_pt ? B_FIN : B_READ;
      B_FIN:  state_d = B_OUT;
      B_OUT:  if (!out_stall_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        job_q <= q_job_i;
        p_q   <= '0;
        acc_q <= '0;
      end
      B_READ: begin
        d_q     <= 2'd0;
        phase_q <= '0;
      end
      B_PREP: begin
        num_q <= DIV_W'(mag);
        neg_q <= mprod[2*IW-1];
        rem_q <= '0;
        cnt_q <= ($clog2(DIV_W))'(DIV_W - 1);
      end
      B_DIV1: begin
        if (cnt_q == '0) begin
          num_q <= {rmod[IW-1:0], {PHASE_W{1'b0}}} + DIV_W'(size_sel[IW:1]);
          rem_q <= '0;
          cnt_q <= ($clog2(DIV_W))'(DIV_W - 1);
        end else begin
          num_q <= num_n;
          rem_q <= rem_n;
          cnt_q <= cnt_q - 1'b1;
        end
      end
      B_DIV2: begin
        num_q <= num_n;
        rem_q <= rem_n;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phase_q <= phase_q + num_n[PHASE_W-1:0];
          d_q     <= d_q + 2'd1;
        end
      end
      B_COS: cos_q <= (quad == 2'd1 || quad == 2'd2) ? -tval : tval;
      B_MUL: prod_q <= $signed(ram_rdata_i[WEIGHT_W-1:0]) * cos_q;
      B_ACC: begin
        acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
        p_q   <= p_q + CNT_W'(1);
      end
      B_FIN: begin
        status_q <= job_q.status;
        if (!(&shifted[ACC_W-1:VALUE_W-1]) && (|shifted[ACC_W-1:VALUE_W-1]))
          value_q <= shifted[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                      : {1'b0, {(VALUE_W-1){1'b1}}};
        else
          value_q <= shifted[VALUE_W-1:0];
      end
      B_OUT: ;
      default: ;
    endcase
  end

endmodule

// File: design/lattice_cosine_transform_unit.sv
// Queries are worked out point by point, using a bit-serial divider that is run twice per axis;
// the back end takes one query at a time, and further queries wait in the job queue.
// Loads are taken one per cycle and proceed while a query runs; clear waits for the back end to drain.
// Reset (async, active low) empties the store and zeroes bounds and index sums; RAM is not cleared.
`timescale 1ns / 1ps
`include "lattice_cosine_transform_unit_macros.svh"
module lattice_cosine_transform_unit import lct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [IW-1:0]       index_x_i,
  input  logic [IW-1:0]       index_y_i,
  input  logic [IW-1:0]       index_z_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VALUE_W-1:0]  value_o,
  output logic [1:0]          status_o
);

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  job_t               q_in;
  job_t               q_out;
  logic               back_idle;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [POINT_W-1:0] ram_wdata;
  logic [POINT_W-1:0] ram_rdata;

  lct_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i,
    .index_x_i, .index_y_i, .index_z_i, .weight_i,
    .back_idle_i (back_idle),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .q_push_o    (q_push),
    .q_job_o     (q_in),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  lct_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lct_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .job_i   (q_in),
    .pop_i   (q_pop),
    .job_o   (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  lct_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i   (q_empty),
    .q_job_i     (q_out),
    .q_pop_o     (q_pop),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .idle_o      (back_idle),
    .out_valid_o, .out_stall_i, .value_o, .status_o
  );

  `LCT_ASSERT_IMP(a_no_overflow, q_push, !q_full)
  `LCT_ASSERT_IMP(a_clear_idle, in_valid_i && !in_stall_o && kind_i == KIND_CLEAR, back_idle && q_empty)
  `LCT_ASSERT_IMP(a_flag_zero, out_valid_o && status_o != STAT_OK, value_o == '0)
  `LCT_ASSERT_NXT(a_pop_leaves_idle, q_pop, !back_idle)

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import lct_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef enum logic [1:0] {CTL_BEAT, CTL_DRAIN, CTL_MODE} ctl_e;

  typedef struct {
    ctl_e             ctl;
    logic [1:0]       kind;
    logic [IW-1:0]    ix;
    logic [IW-1:0]    iy;
    logic [IW-1:0]    iz;
    logic [WEIGHT_W-1:0] w;
    int               mode;
  } beat_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
  } sum_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = KIND_LOAD;
  logic [IW-1:0] ix = '0, iy = '0, iz = '0;
  logic [WEIGHT_W-1:0] w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VALUE_W-1:0] value;
  logic [1:0] status;

  beat_t pending[$];
  sum_t  sums_due[$];
  int    snd_idle = 22, rcv_idle = 73;
  int    errors = 0;
  int unsigned cycles = 0;

  int     cos_q[COS_LEN];
  int     pt_idx[MAX_POINTS][3];
  longint pt_w[MAX_POINTS];
  int     pt_count;
  int     lo_b[3], hi_b[3];
  longint idx_sum[3];

  lattice_cosine_transform_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .index_x_i(ix), .index_y_i(iy), .index_z_i(iz), .weight_i(w),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .value_o(value), .status_o(status)
  );

  always #5 clk_i = ~clk_i;

  function automatic void fill_cos_quarter();
    longint a, a2, t, s, r;
    for (int e = 0; e < COS_LEN - 1; e++) begin
      a  = (64'sd1686629713 * longint'(e)) >>> COS_TABLE_BITS;
      a2 = (a * a) / (64'sd1 << 30);
      t  = 64'sd1 << 30;
      s  = t;
      for (int k = 1; k <= 10; k++) begin
        t = -((t * a2) / (64'sd1 << 30) / longint'((2 * k - 1) * (2 * k)));
        s += t;
      end
      if (s < 0) s = 0;
      r = (s * 32767 + (64'sd1 << 29)) / (64'sd1 << 30);
      cos_q[e] = (r > 32767) ? 32767 : int'(r);
    end
    cos_q[COS_LEN-1] = 0;
  endfunction

  function automatic void empty_store();
    pt_count = 0;
    for (int d = 0; d < 3; d++) begin
      lo_b[d] = 0; hi_b[d] = 0; idx_sum[d] = 0;
    end
  endfunction

  function automatic longint phase_of(longint q, longint n, longint sz);
    longint r;
    r = (q * n) % sz;
    if (r < 0) r += sz;
    return (r * 65536 + sz / 2) / sz;
  endfunction

  function automatic int cos_of(logic [15:0] ph);
    logic [1:0] quad;
    int m;
    quad = ph[15:14];
    m = int'(ph[13:14-COS_TABLE_BITS]);
    case (quad)
      2'd0: return cos_q[m];
      2'd1: return -cos_q[(1 << COS_TABLE_BITS) - m];
      2'd2: return -cos_q[m];
      default: return cos_q[(1 << COS_TABLE_BITS) - m];
    endcase
  endfunction

  function automatic void apply_beat(logic [1:0] k, logic [IW-1:0] a, logic [IW-1:0] b,
                                     logic [IW-1:0] c, logic [WEIGHT_W-1:0] wt);
    int q[3];
    sum_t res;
    longint acc, sz[3], v;
    logic [15:0] ph;
    q[0] = int'($signed(a)); q[1] = int'($signed(b)); q[2] = int'($signed(c));
    if (k == KIND_LOAD) begin
      if (pt_count < MAX_POINTS) begin
        for (int d = 0; d < 3; d++) begin
          pt_idx[pt_count][d] = q[d];
          if (q[d] < lo_b[d]) lo_b[d] = q[d];
          if (q[d] > hi_b[d]) hi_b[d] = q[d];
          idx_sum[d] += q[d];
        end
        pt_w[pt_count] = longint'($signed(wt));
        pt_count++;
      end
    end else if (k == KIND_CLEAR) begin
      empty_store();
    end else if (k == KIND_QUERY) begin
      res.status = STAT_OK;
      v = 0;
      if (pt_count == 0) res.status = STAT_EMPTY;
      else if (idx_sum[0] != 0 || idx_sum[1] != 0 || idx_sum[2] != 0)
        res.status = STAT_NOT_FULL;
      else
        for (int d = 0; d < 3; d++)
          if (q[d] < lo_b[d] || q[d] > hi_b[d]) res.status = STAT_OUTSIDE;
      if (res.status == STAT_OK) begin
        acc = 0;
        for (int d = 0; d < 3; d++) sz[d] = hi_b[d] - lo_b[d] + 1;
        for (int p = 0; p < pt_count; p++) begin
          ph = '0;
          for (int d = 0; d < 3; d++) ph += 16'(phase_of(q[d], pt_idx[p][d], sz[d]));
          acc += pt_w[p] * longint'(cos_of(ph));
        end
        v = acc >>> 8;
        if (v > (64'sd1 << 47) - 1) v = (64'sd1 << 47) - 1;
        if (v < -(64'sd1 << 47)) v = -(64'sd1 << 47);
      end
      res.value = v[VALUE_W-1:0];
      sums_due.push_back(res);
    end
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("  %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending[0].ctl == CTL_DRAIN) begin
        in_valid <= 1'b0;
        if (!in_valid && sums_due.size() == 0) void'(pending.pop_front());
      end else if (pending[0].ctl == CTL_MODE) begin
        in_valid <= 1'b0;
        snd_idle <= (pending[0].mode == 0) ? 22 : (pending[0].mode == 1) ? 73 : 0;
        rcv_idle <= (pending[0].mode == 0) ? 73 : (pending[0].mode == 1) ? 22 : 0;
        void'(pending.pop_front());
      end else if ($urandom_range(99) < snd_idle) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        kind <= pending[0].kind;
        ix <= pending[0].ix;
        iy <= pending[0].iy;
        iz <= pending[0].iz;
        w <= pending[0].w;
        void'(pending.pop_front());
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sum_t due;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      cycles++;
      if (in_valid && !in_stall) apply_beat(kind, ix, iy, iz, w);
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          report("unexpected beat", {14'b0, status, value}, 0);
        end else begin
          due = sums_due.pop_front();
          if (status !== due.status) report("status", status, due.status);
          if (value !== due.value) report("value", value, due.value);
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle);
      if (cycles > CYCLE_LIMIT) begin
        $display("lattice_cosine_transform_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic push(logic [1:0] k, int a, int b, int c, logic [31:0] wt);
    beat_t e;
    e.ctl = CTL_BEAT; e.kind = k; e.mode = 0;
    e.ix = IW'(a); e.iy = IW'(b); e.iz = IW'(c); e.w = wt;
    pending.push_back(e);
  endtask

  task automatic push_ctl(ctl_e c, int m);
    beat_t e;
    e = '{ctl: c, mode: m, default: '0};
    pending.push_back(e);
  endtask

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic random_set(inout int n);
    int np, span, p[3], mn[3], mx[3], q[3];
    for (int d = 0; d < 3; d++) begin mn[d] = 0; mx[d] = 0; end
    push(KIND_CLEAR, pick(-128, 127), 0, 0, $urandom);
    np = ($urandom_range(9) == 0) ? pick(8, 20) : pick(1, 4);
    span = ($urandom_range(3) == 0) ? 127 : pick(1, 6);
    n += 1 + 2 * np;
    for (int i = 0; i < np; i++) begin
      for (int d = 0; d < 3; d++) begin
        p[d] = pick(-span, span);
        if (-p[d] < mn[d] || p[d] < mn[d]) mn[d] = (p[d] < 0) ? p[d] : -p[d];
        if (-p[d] > mx[d] || p[d] > mx[d]) mx[d] = (p[d] > 0) ? p[d] : -p[d];
      end
      push(KIND_LOAD, p[0], p[1], p[2], $urandom);
      push(KIND_LOAD, -p[0], -p[1], -p[2], $urandom);
    end
    if ($urandom_range(7) == 0) begin
      push(KIND_LOAD, -128, 127, 1, $urandom);
      push(KIND_LOAD, 127, -128, -128, $urandom);
      push(KIND_LOAD, 1, 1, 127, $urandom);
      for (int d = 0; d < 3; d++) begin mn[d] = -128; mx[d] = 127; end
      n += 3;
    end
    if ($urandom_range(9) == 0) begin
      push(KIND_LOAD, pick(-128, 127), pick(-128, 127), pick(-128, 127), $urandom);
      n++;
    end
    if ($urandom_range(9) == 0) push(KIND_SPARE, pick(-128, 127), 0, 0, $urandom);
    repeat (pick(1, 3)) begin
      for (int d = 0; d < 3; d++)
        q[d] = ($urandom_range(7) == 0) ? pick(-128, 127) : pick(mn[d], mx[d]);
      push(KIND_QUERY, q[0], q[1], q[2], $urandom);
      n++;
    end
  endtask

  initial begin
    int n;
    fill_cos_quarter();
    empty_store();
    push(KIND_QUERY, 0, 0, 0, 0);
    push(KIND_LOAD, 1, 0, 0, 32'h7fffffff);
    push(KIND_QUERY, 0, 0, 0, 0);
    push(KIND_LOAD, -1, 0, 0, 32'h80000000);
    push(KIND_QUERY, 0, 0, 0, 0);
    push(KIND_QUERY, 1, 0, 0, 0);
    push(KIND_QUERY, -1, 0, 0, 0);
    push(KIND_QUERY, 2, 0, 0, 0);
    push(KIND_SPARE, 1, 1, 1, 32'hffffffff);
    push(KIND_CLEAR, 0, 0, 0, 0);
    push(KIND_QUERY, 0, 0, 0, 0);
    push(KIND_LOAD, -128, -128, -128, 32'hffffffff);
    push(KIND_LOAD, 127, 127, 127, 32'h0);
    push(KIND_LOAD, 1, 1, 1, 32'h01000000);
    push(KIND_QUERY, -128, 127, 0, 0);
    push(KIND_QUERY, 127, -128, 5, 0);
    push(KIND_QUERY, 127, 127, -128, 0);
    push_ctl(CTL_DRAIN, 0);
    for (int m = 0; m < 3; m++) begin
      push_ctl(CTL_MODE, m);
      n = 0;
      while (n < 185) random_set(n);
      push_ctl(CTL_DRAIN, 0);
    end
    #20 rst_ni = 1'b1;
    wait (pending.size() == 0 && !in_valid && sums_due.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && sums_due.size() == 0) begin
      $display("lattice_cosine_transform_unit: match");
    end else begin
      $display("lattice_cosine_transform_unit: mismatch");
    end
    $finish;
  end

endmodule
